// ----- hw/rtl/nfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// nfpa_pkg
// Shared constants, codes and controller/datapath bundles of the next-fit
// page allocator.
// ----------------------------------------------------------------------------
package nfpa_pkg;

  // Page geometry.
  localparam int unsigned PAGE_BYTES = 8192;
  localparam int unsigned MAX_PAGES  = 1024;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W     = $clog2(MAX_PAGES);
  localparam int unsigned PCNT_W     = PAGE_W + 1;

  // The page-used bitmap is kept as rows of ROW_BITS flags.
  localparam int unsigned ROW_BITS = 32;
  localparam int unsigned ROW_W    = $clog2(ROW_BITS);
  localparam int unsigned NUM_ROWS = MAX_PAGES / ROW_BITS;
  localparam int unsigned ROWS_W   = $clog2(NUM_ROWS);
  localparam int unsigned VISIT_W  = ROWS_W + 1;

  // Field widths.
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned REQ_W     = 21;
  localparam int unsigned SIZE_W    = 25;
  localparam int unsigned SSIZE_W   = 21;
  localparam int unsigned OPC_W     = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  // Register reset values.
  localparam logic [SIZE_W-1:0]  REGION_SIZE_RST = SIZE_W'(8388608);
  localparam logic [SSIZE_W-1:0] STATIC_SIZE_RST = SSIZE_W'(1024 + (4096 * 4));

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_SIZE = 2'd2;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_STATIC   = 2'd2,
    OP_FREE_ALL = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_NO_PAGE      = 3'd2,
    ST_STATIC_OUT   = 3'd3,
    ST_RANGE        = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    CMD_IDLE       = 4'd0,
    CMD_CAPTURE    = 4'd1,
    CMD_PREP       = 4'd2,
    CMD_ALLOC_INIT = 4'd3,
    CMD_TOO_LARGE  = 4'd4,
    CMD_ROW_READ   = 4'd5,
    CMD_ROW_CHECK  = 4'd6,
    CMD_NO_PAGE    = 4'd7,
    CMD_GRANT_ADDR = 4'd8,
    CMD_FREE_INIT  = 4'd9,
    CMD_RANGE_ERR  = 4'd10,
    CMD_FREE_READ  = 4'd11,
    CMD_FREE_CHECK = 4'd12,
    CMD_STATIC     = 4'd13,
    CMD_FREE_ALL   = 4'd14,
    CMD_EMIT       = 4'd15
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    oversize;
    logic    in_range;
    logic    row_hit;
    logic    search_over;
    logic    out_full;
  } dp_stat_t;

endpackage

// ----- hw/rtl/nfpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// nfpa_ctrl
// Sequencer of the allocator: walks each request through its datapath steps.
// ----------------------------------------------------------------------------
module nfpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  nfpa_pkg::dp_stat_t stat,
  output nfpa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DISPATCH,
    S_ROW_READ,
    S_ROW_CHECK,
    S_GRANT,
    S_FREE_RANGE,
    S_FREE_CHECK,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = nfpa_pkg::CMD_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = nfpa_pkg::CMD_CAPTURE;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op    = nfpa_pkg::CMD_PREP;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.opcode)
          nfpa_pkg::OP_ALLOC: begin
            if (stat.oversize) begin
              cmd.op    = nfpa_pkg::CMD_TOO_LARGE;
              state_nxt = S_FINISH;
            end else begin
              cmd.op    = nfpa_pkg::CMD_ALLOC_INIT;
              state_nxt = S_ROW_READ;
            end
          end
          nfpa_pkg::OP_FREE: begin
            cmd.op    = nfpa_pkg::CMD_FREE_INIT;
            state_nxt = S_FREE_RANGE;
          end
          nfpa_pkg::OP_STATIC: begin
            cmd.op    = nfpa_pkg::CMD_STATIC;
            state_nxt = S_FINISH;
          end
          default: begin
            cmd.op    = nfpa_pkg::CMD_FREE_ALL;
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_ROW_READ: begin
        if (stat.search_over) begin
          cmd.op    = nfpa_pkg::CMD_NO_PAGE;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = nfpa_pkg::CMD_ROW_READ;
          state_nxt = S_ROW_CHECK;
        end
      end
      S_ROW_CHECK: begin
        cmd.op    = nfpa_pkg::CMD_ROW_CHECK;
        state_nxt = stat.row_hit ? S_GRANT : S_ROW_READ;
      end
      S_GRANT: begin
        cmd.op    = nfpa_pkg::CMD_GRANT_ADDR;
        state_nxt = S_FINISH;
      end
      S_FREE_RANGE: begin
        if (stat.in_range) begin
          cmd.op    = nfpa_pkg::CMD_FREE_READ;
          state_nxt = S_FREE_CHECK;
        end else begin
          cmd.op    = nfpa_pkg::CMD_RANGE_ERR;
          state_nxt = S_FINISH;
        end
      end
      S_FREE_CHECK: begin
        cmd.op    = nfpa_pkg::CMD_FREE_CHECK;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // Hand the result to the output register once it has room.
        if (!stat.out_full) begin
          cmd.op    = nfpa_pkg::CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/nfpa_dp.sv -----
// ----------------------------------------------------------------------------
// nfpa_dp
// Datapath of the allocator: configuration registers, page bitmap memory,
// next-fit row scanner, free decoder, static bump pointer and result register.
// ----------------------------------------------------------------------------
module nfpa_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nfpa_pkg::dp_cmd_t                 cmd,
  output nfpa_pkg::dp_stat_t                stat,
  input  logic [nfpa_pkg::OPC_W-1:0]        in_opcode,
  input  logic [nfpa_pkg::REQ_W-1:0]        in_request_size,
  input  logic [nfpa_pkg::ADDR_W-1:0]       in_free_address,
  input  logic                              cfg_we,
  input  logic [nfpa_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [nfpa_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nfpa_pkg::ADDR_W-1:0]       out_granted_address,
  output logic [nfpa_pkg::PAGE_W-1:0]       out_page_number,
  output logic [nfpa_pkg::STATUS_W-1:0]     out_status
);

  localparam int unsigned QW    = nfpa_pkg::SIZE_W - nfpa_pkg::PAGE_SHIFT;
  localparam int unsigned OFF_W = nfpa_pkg::ADDR_W + 2;

  // Configuration registers.
  logic [nfpa_pkg::ADDR_W-1:0]  region_base_r;
  logic [nfpa_pkg::SIZE_W-1:0]  region_size_r;
  logic [nfpa_pkg::SSIZE_W-1:0] static_size_r;

  // Request fields.
  nfpa_pkg::opcode_t             opcode_r;
  logic [nfpa_pkg::REQ_W-1:0]    req_r;
  logic [nfpa_pkg::ADDR_W-1:0]   faddr_r;

  // Per-request derived values.
  logic [nfpa_pkg::PCNT_W-1:0]   pages_r;
  logic [nfpa_pkg::ADDR_W:0]     first_r;
  logic [nfpa_pkg::ROWS_W-1:0]   last_row_r;
  logic [nfpa_pkg::VISIT_W-1:0]  nrows_r;
  logic [OFF_W-1:0]              off_r;

  // Search state.
  logic [nfpa_pkg::PAGE_W-1:0]   search_start_r;
  logic [nfpa_pkg::ROWS_W-1:0]   row_r;
  logic [nfpa_pkg::ROW_W-1:0]    start_bit_r;
  logic                          first_visit_r;
  logic [nfpa_pkg::VISIT_W-1:0]  visit_r;

  logic [nfpa_pkg::ADDR_W-1:0]   static_used_r;

  // Bitmap memory; a row whose valid bit is clear reads as all free.
  logic [nfpa_pkg::ROW_BITS-1:0] mem [nfpa_pkg::NUM_ROWS];
  logic [nfpa_pkg::NUM_ROWS-1:0] row_vld_r;
  logic [nfpa_pkg::ROW_BITS-1:0] rd_data_r;
  logic [nfpa_pkg::ROWS_W-1:0]   chk_row_r;

  // Result being built and output register.
  logic [nfpa_pkg::ADDR_W-1:0]   res_addr_r;
  logic [nfpa_pkg::PAGE_W-1:0]   res_page_r;
  nfpa_pkg::status_t             res_status_r;
  logic                          out_valid_r;
  logic [nfpa_pkg::ADDR_W-1:0]   out_addr_r;
  logic [nfpa_pkg::PAGE_W-1:0]   out_page_r;
  nfpa_pkg::status_t             out_status_r;

  // Combinational helpers.
  logic [nfpa_pkg::SIZE_W-1:0]   size_diff;
  logic                          static_gt;
  logic [QW-1:0]                 quot;
  logic [nfpa_pkg::PCNT_W-1:0]   pages_nxt;
  logic [nfpa_pkg::PCNT_W-1:0]   pages_m1;
  logic [nfpa_pkg::PAGE_W-1:0]   start_j;
  logic [nfpa_pkg::ROW_BITS-1:0] eff_word;
  logic [nfpa_pkg::ROW_BITS-1:0] free_mask;
  logic [nfpa_pkg::ROW_W-1:0]    hit_bit;
  logic                          row_hit;
  logic [nfpa_pkg::PAGE_W-1:0]   free_idx;
  logic                          in_range;
  logic                          mem_we;
  logic [nfpa_pkg::ROWS_W-1:0]   mem_wa;
  logic [nfpa_pkg::ROW_BITS-1:0] mem_wd;
  logic                          mem_re;
  logic [nfpa_pkg::ROWS_W-1:0]   mem_ra;
  logic                          static_out;

  assign static_gt = {{(nfpa_pkg::SIZE_W-nfpa_pkg::SSIZE_W){1'b0}}, static_size_r} > region_size_r;
  assign size_diff = region_size_r
                     - {{(nfpa_pkg::SIZE_W-nfpa_pkg::SSIZE_W){1'b0}}, static_size_r};
  assign quot      = size_diff[nfpa_pkg::SIZE_W-1:nfpa_pkg::PAGE_SHIFT];

  always_comb begin
    if (static_gt) begin
      pages_nxt = '0;
    end else if (quot > QW'(nfpa_pkg::MAX_PAGES)) begin
      pages_nxt = nfpa_pkg::PCNT_W'(nfpa_pkg::MAX_PAGES);
    end else begin
      pages_nxt = quot[nfpa_pkg::PCNT_W-1:0];
    end
  end

  assign pages_m1 = pages_nxt - nfpa_pkg::PCNT_W'(1);

  // A stale start point, left over from a larger page count, restarts at zero.
  assign start_j = ({1'b0, search_start_r} < pages_r) ? search_start_r : '0;

  assign eff_word = row_vld_r[chk_row_r] ? rd_data_r : '0;

  always_comb begin
    for (int b = 0; b < int'(nfpa_pkg::ROW_BITS); b++) begin
      free_mask[b] = !eff_word[b]
                     && ({1'b0, chk_row_r, nfpa_pkg::ROW_W'(b)} < pages_r)
                     && (!first_visit_r || (nfpa_pkg::ROW_W'(b) >= start_bit_r));
    end
  end

  always_comb begin
    hit_bit = '0;
    for (int b = int'(nfpa_pkg::ROW_BITS) - 1; b >= 0; b--) begin
      if (free_mask[b]) begin
        hit_bit = nfpa_pkg::ROW_W'(b);
      end
    end
  end

  assign row_hit = |free_mask;

  // The offset is negative below the first page; the tail check is on the
  // page index of the offset.
  assign free_idx = off_r[nfpa_pkg::PAGE_SHIFT +: nfpa_pkg::PAGE_W];
  assign in_range = !off_r[OFF_W-1]
                    && (off_r[OFF_W-2:nfpa_pkg::PAGE_SHIFT]
                        < (OFF_W-1-nfpa_pkg::PAGE_SHIFT)'(pages_r));

  assign static_out = static_used_r >= nfpa_pkg::ADDR_W'(static_size_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = chk_row_r;
    mem_wd = eff_word;
    mem_re = 1'b0;
    mem_ra = row_r;
    case (cmd.op)
      nfpa_pkg::CMD_ROW_READ: begin
        mem_re = 1'b1;
      end
      nfpa_pkg::CMD_FREE_READ: begin
        mem_re = 1'b1;
        mem_ra = free_idx[nfpa_pkg::PAGE_W-1:nfpa_pkg::ROW_W];
      end
      nfpa_pkg::CMD_ROW_CHECK: begin
        mem_we = row_hit;
        mem_wd = eff_word | (nfpa_pkg::ROW_BITS'(1) << hit_bit);
      end
      nfpa_pkg::CMD_FREE_CHECK: begin
        mem_we = eff_word[free_idx[nfpa_pkg::ROW_W-1:0]];
        mem_wd = eff_word & ~(nfpa_pkg::ROW_BITS'(1) << free_idx[nfpa_pkg::ROW_W-1:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r  <= '0;
      region_size_r  <= nfpa_pkg::REGION_SIZE_RST;
      static_size_r  <= nfpa_pkg::STATIC_SIZE_RST;
      search_start_r <= '0;
      static_used_r  <= '0;
      row_vld_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          nfpa_pkg::CFG_REGION_BASE: region_base_r <= cfg_wdata;
          nfpa_pkg::CFG_REGION_SIZE: region_size_r <= cfg_wdata[nfpa_pkg::SIZE_W-1:0];
          nfpa_pkg::CFG_STATIC_SIZE: static_size_r <= cfg_wdata[nfpa_pkg::SSIZE_W-1:0];
          default: begin
          end
        endcase
      end
      // A new result may load in the same cycle that the old beat leaves.
      out_valid_r <= (cmd.op == nfpa_pkg::CMD_EMIT) || (out_valid_r && !out_ready);
      case (cmd.op)
        nfpa_pkg::CMD_ROW_CHECK: begin
          if (row_hit) begin
            row_vld_r[chk_row_r] <= 1'b1;
            search_start_r       <= {chk_row_r, hit_bit};
          end
        end
        nfpa_pkg::CMD_FREE_CHECK: begin
          if (eff_word[free_idx[nfpa_pkg::ROW_W-1:0]]) begin
            row_vld_r[chk_row_r] <= 1'b1;
          end
        end
        nfpa_pkg::CMD_STATIC: begin
          if (!static_out) begin
            static_used_r <= static_used_r + nfpa_pkg::ADDR_W'(req_r);
          end
        end
        nfpa_pkg::CMD_FREE_ALL: begin
          row_vld_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      nfpa_pkg::CMD_CAPTURE: begin
        opcode_r <= nfpa_pkg::opcode_t'(in_opcode);
        req_r    <= in_request_size;
        faddr_r  <= in_free_address;
      end
      nfpa_pkg::CMD_PREP: begin
        pages_r    <= pages_nxt;
        first_r    <= {1'b0, region_base_r} + (nfpa_pkg::ADDR_W+1)'(static_size_r);
        last_row_r <= pages_m1[nfpa_pkg::PAGE_W-1:nfpa_pkg::ROW_W];
        nrows_r    <= pages_nxt[nfpa_pkg::PCNT_W-1:nfpa_pkg::ROW_W]
                      + nfpa_pkg::VISIT_W'(|pages_nxt[nfpa_pkg::ROW_W-1:0]);
      end
      nfpa_pkg::CMD_ALLOC_INIT: begin
        row_r         <= start_j[nfpa_pkg::PAGE_W-1:nfpa_pkg::ROW_W];
        start_bit_r   <= start_j[nfpa_pkg::ROW_W-1:0];
        first_visit_r <= 1'b1;
        visit_r       <= '0;
      end
      nfpa_pkg::CMD_TOO_LARGE: begin
        res_addr_r   <= '0;
        res_page_r   <= '0;
        res_status_r <= nfpa_pkg::ST_TOO_LARGE;
      end
      nfpa_pkg::CMD_ROW_READ: begin
        chk_row_r <= row_r;
      end
      nfpa_pkg::CMD_ROW_CHECK: begin
        if (row_hit) begin
          res_page_r   <= {chk_row_r, hit_bit};
          res_status_r <= nfpa_pkg::ST_OK;
        end else begin
          // Move on to the next row, wrapping after the last populated row.
          first_visit_r <= 1'b0;
          visit_r       <= visit_r + nfpa_pkg::VISIT_W'(1);
          row_r         <= (row_r == last_row_r) ? '0 : row_r + nfpa_pkg::ROWS_W'(1);
        end
      end
      nfpa_pkg::CMD_NO_PAGE: begin
        res_addr_r   <= '0;
        res_page_r   <= '0;
        res_status_r <= nfpa_pkg::ST_NO_PAGE;
      end
      nfpa_pkg::CMD_GRANT_ADDR: begin
        res_addr_r <= first_r[nfpa_pkg::ADDR_W-1:0]
                      + (nfpa_pkg::ADDR_W'(res_page_r) << nfpa_pkg::PAGE_SHIFT);
      end
      nfpa_pkg::CMD_FREE_INIT: begin
        off_r <= {2'b00, faddr_r} - {1'b0, first_r};
      end
      nfpa_pkg::CMD_RANGE_ERR: begin
        res_addr_r   <= '0;
        res_page_r   <= '0;
        res_status_r <= nfpa_pkg::ST_RANGE;
      end
      nfpa_pkg::CMD_FREE_READ: begin
        chk_row_r <= free_idx[nfpa_pkg::PAGE_W-1:nfpa_pkg::ROW_W];
      end
      nfpa_pkg::CMD_FREE_CHECK: begin
        res_addr_r   <= '0;
        res_page_r   <= free_idx;
        res_status_r <= eff_word[free_idx[nfpa_pkg::ROW_W-1:0]]
                        ? nfpa_pkg::ST_OK : nfpa_pkg::ST_ALREADY_FREE;
      end
      nfpa_pkg::CMD_STATIC: begin
        res_page_r <= '0;
        if (static_out) begin
          res_addr_r   <= '0;
          res_status_r <= nfpa_pkg::ST_STATIC_OUT;
        end else begin
          res_addr_r   <= region_base_r + static_used_r;
          res_status_r <= nfpa_pkg::ST_OK;
        end
      end
      nfpa_pkg::CMD_FREE_ALL: begin
        res_addr_r   <= '0;
        res_page_r   <= '0;
        res_status_r <= nfpa_pkg::ST_OK;
      end
      nfpa_pkg::CMD_EMIT: begin
        out_addr_r   <= res_addr_r;
        out_page_r   <= res_page_r;
        out_status_r <= res_status_r;
      end
      default: begin
      end
    endcase
  end

  assign stat.opcode      = opcode_r;
  assign stat.oversize    = req_r > nfpa_pkg::REQ_W'(nfpa_pkg::PAGE_BYTES);
  assign stat.in_range    = in_range;
  assign stat.row_hit     = row_hit;
  assign stat.search_over = visit_r > nrows_r;
  assign stat.out_full    = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_page_number     = out_page_r;
  assign out_status          = out_status_r;

endmodule

// ----- hw/rtl/next_fit_page_allocator.sv -----
// ----------------------------------------------------------------------------
// next_fit_page_allocator
// Page allocator over a buffer region: bump-pointer static area followed by
// fixed pages handed out next-fit from a page-used bitmap.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  in_      sink       tuser: opcode; tdata: request_size, free_address
//  out_     source     tuser: status; tdata: granted_address, page_number
//  cfg_     sink       cfg_index selects region_base, region_size, static_size
//
//  One request is handled at a time. Allocate reads and checks the bitmap one
//  32-page row at a time until it finds a free page or has come back round to
//  its start row. Reset is synchronous; per-row valid flags free every page at
//  once, so the bitmap needs no clearing pass. A result waiting in the output
//  register holds off the next request only when that one must be loaded.
//
module next_fit_page_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [20:0] request_size, [52:21] free_address
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] granted_address, [41:32] page_number
  output logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  nfpa_pkg::dp_cmd_t  cmd;
  nfpa_pkg::dp_stat_t stat;

  logic [nfpa_pkg::ADDR_W-1:0] granted_address;
  logic [nfpa_pkg::PAGE_W-1:0] page_number;

  assign cfg_ready = 1'b1;

  nfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfpa_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_tuser),
    .in_request_size     (in_tdata[20:0]),
    .in_free_address     (in_tdata[52:21]),
    .cfg_we              (cfg_valid),
    .cfg_idx             (cfg_index),
    .cfg_wdata           (cfg_data),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .out_granted_address (granted_address),
    .out_page_number     (page_number),
    .out_status          (out_tuser)
  );

  assign out_tdata = {6'd0, page_number, granted_address};

endmodule
